FILE: hdl/cbe_pkg.sv
// Shared constants for the cubic-bezier easing block.
`default_nettype none

package cbe_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ITERATIONS = 32;
  localparam int DEF_FRAC_BITS      = 32;

  // Digit width of the shared multiplier (operand B is consumed this many bits a cycle)
  localparam int DIG = 16;

  // Q16 widths of the ports
  localparam int PROG_W = 18;
  localparam int EASE_W = 20;
  localparam int CX_W   = 17;
  localparam int CY_W   = 20;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 4;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_X1 = 4'd0;
  localparam logic [IDX_W-1:0] REG_Y1 = 4'd1;
  localparam logic [IDX_W-1:0] REG_X2 = 4'd2;
  localparam logic [IDX_W-1:0] REG_Y2 = 4'd3;

  // Q16 one, and the saturation limits of the result word
  localparam logic [CX_W-1:0] Q16_ONE  = 17'd65536;
  localparam logic [23:0]     SAT_NEG  = 24'd524288;
  localparam logic [23:0]     SAT_POS  = 24'd524287;

endpackage : cbe_pkg

`default_nettype wire

FILE: hdl/cubic_bezier_easing.sv
// Cubic-bezier easing: bisection on x(t), then y(t), on one shared multiplier.
`default_nettype none

// Channel   | Ports                                    | Dir | Handshake
// ----------+------------------------------------------+-----+------------------------------
// input     | start, progress_i                        | in  | taken when start & !busy
// busy      | busy                                     | out | high while a word is in work
// result    | valid_o, eased_o                         | out | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_idx_i, cfg_data_i          | in  | write when cfg_we_i, no wait
//
// Sequence: a progress at or outside the ends gives its result in the cycle after
//   it is taken. Otherwise every curve evaluation is 7 products, each a load, ND
//   digits of the shared multiplier, ND = ceil((INTERNAL_FRAC_BITS+1)/16), and a
//   store; each bisection step adds a compare, and the y evaluation ends in a
//   rounding step and the output step.
// The multiplier, a (F+4) x 16-bit unit with a rounding accumulator, sets the pace.
// Reset: asynchronous, active low; control points return to the linear curve.
// Stalls: none; the receiver takes every result word in the strobe cycle.
module cubic_bezier_easing #(
  parameter int MAX_ITERATIONS     = cbe_pkg::DEF_MAX_ITERATIONS,
  parameter int INTERNAL_FRAC_BITS = cbe_pkg::DEF_FRAC_BITS
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  signed [cbe_pkg::PROG_W-1:0]    progress_i,
  output logic                                 valid_o,
  output logic signed [cbe_pkg::EASE_W-1:0]    eased_o,
  input  wire                                  cfg_we_i,
  input  wire         [cbe_pkg::IDX_W-1:0]     cfg_idx_i,
  input  wire         [cbe_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int F   = INTERNAL_FRAC_BITS;
  localparam int DIG = cbe_pkg::DIG;
  localparam int TW  = F + 1;                 // t, u, weights in [0, 1]
  localparam int AW  = F + 4;                 // operand A / product magnitude
  localparam int ND  = (TW + DIG - 1) / DIG;  // digits of operand B
  localparam int BW  = ND * DIG;
  localparam int PW  = AW + BW;               // accumulator
  localparam int SW  = F + 8;                 // signed curve sum
  localparam int KW  = (ND > 1) ? $clog2(ND) : 1;
  localparam int IW  = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam int RW  = SW - (F - 16);         // rounded Q16 magnitude

  localparam logic [63:0]   TOL64 = ((64'd1 << F) + 64'd500000) / 64'd1000000;
  localparam logic [SW-1:0] TOL   = TOL64[SW-1:0];
  localparam logic [TW-1:0] ONE   = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] HALF  = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [SW-1:0] RHALF = {{(SW-F+16){1'b0}}, 1'b1, {(F-17){1'b0}}};
  localparam logic [KW-1:0] K_LAST  = KW'(ND - 1);
  localparam logic [IW-1:0] IT_LAST = IW'(MAX_ITERATIONS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // products of one curve evaluation, in issue order
  localparam logic [2:0] OP_UU = 3'd0;
  localparam logic [2:0] OP_TT = 3'd1;
  localparam logic [2:0] OP_W1 = 3'd2;
  localparam logic [2:0] OP_W2 = 3'd3;
  localparam logic [2:0] OP_W3 = 3'd4;
  localparam logic [2:0] OP_S1 = 3'd5;
  localparam logic [2:0] OP_S2 = 3'd6;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [cbe_pkg::CX_W-1:0] cx1_q, cx2_q;
  logic [cbe_pkg::CY_W-1:0] cy1_q, cy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx1_q <= '0;
      cy1_q <= '0;
      cx2_q <= cbe_pkg::Q16_ONE;
      cy2_q <= cbe_pkg::CY_W'(cbe_pkg::Q16_ONE);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbe_pkg::REG_X1: cx1_q <= cfg_data_i[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_Y1: cy1_q <= cfg_data_i[cbe_pkg::CY_W-1:0];
        cbe_pkg::REG_X2: cx2_q <= cfg_data_i[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_Y2: cy2_q <= cfg_data_i[cbe_pkg::CY_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // Control point magnitudes in Q(F); x clamped to 1, y taken as sign/magnitude
  logic [cbe_pkg::CX_W-1:0] x1c, x2c;
  logic [cbe_pkg::CY_W-1:0] y1m, y2m;
  logic                     y1neg, y2neg;
  logic [AW-1:0]            p1_abs, p2_abs;
  logic                     p1_neg, p2_neg;

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0]    state_q, state_d;
  logic [2:0]    op_q, op_d;
  logic          mode_q, mode_d;      // 0: solving x, 1: evaluating y
  logic [KW-1:0] k_q, k_d;
  logic [IW-1:0] it_q, it_d;
  logic          valid_q, valid_d;

  logic [TW-1:0] x_q, x_d, t_q, t_d, u_q, u_d, lo_q, lo_d, hi_q, hi_d;
  logic [TW-1:0] uu_q, uu_d, tt_q, tt_d, w1_q, w1_d, w2_q, w2_d;
  logic [AW-1:0] a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic [PW-1:0] acc_q, acc_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic          rneg_q, rneg_d;
  logic signed [cbe_pkg::EASE_W-1:0] eased_q, eased_d;

  always_comb begin
    x1c    = (cx1_q > cbe_pkg::Q16_ONE) ? cbe_pkg::Q16_ONE : cx1_q;
    x2c    = (cx2_q > cbe_pkg::Q16_ONE) ? cbe_pkg::Q16_ONE : cx2_q;
    y1neg  = cy1_q[cbe_pkg::CY_W-1];
    y2neg  = cy2_q[cbe_pkg::CY_W-1];
    y1m    = y1neg ? (~cy1_q + 1'b1) : cy1_q;
    y2m    = y2neg ? (~cy2_q + 1'b1) : cy2_q;
    p1_abs = mode_q ? {y1m, {(F-16){1'b0}}} : AW'({x1c, {(F-16){1'b0}}});
    p2_abs = mode_q ? {y2m, {(F-16){1'b0}}} : AW'({x2c, {(F-16){1'b0}}});
    p1_neg = mode_q & y1neg;
    p2_neg = mode_q & y2neg;
  end

  // Operand select for the product in hand
  logic [AW-1:0] op_a;
  logic [TW-1:0] op_b;
  logic          op_neg;

  always_comb begin
    op_neg = 1'b0;
    unique case (op_q)
      OP_UU:   begin op_a = AW'(u_q);  op_b = u_q;  end
      OP_TT:   begin op_a = AW'(t_q);  op_b = t_q;  end
      OP_W1:   begin op_a = AW'(t_q);  op_b = uu_q; end
      OP_W2:   begin op_a = AW'(u_q);  op_b = tt_q; end
      OP_W3:   begin op_a = AW'(t_q);  op_b = tt_q; end
      OP_S1:   begin op_a = p1_abs;    op_b = w1_q; op_neg = p1_neg; end
      OP_S2:   begin op_a = p2_abs;    op_b = w2_q; op_neg = p2_neg; end
      default: begin op_a = '0;        op_b = '0;   end
    endcase
  end

  // Shared multiplier: A times one 16-bit digit of B, placed by the digit count
  logic [AW+DIG-1:0] pp;
  logic [PW-1:0]     pp_sh;
  logic [AW-1:0]     res;
  logic [SW-1:0]     res3;

  always_comb begin
    pp    = {{DIG{1'b0}}, a_q} * {{AW{1'b0}}, b_q[DIG-1:0]};
    pp_sh = {{(BW-DIG){1'b0}}, pp} << (DIG * k_q);
    res   = acc_q[F +: AW];                   // rounded product, Q(F)
    res3  = SW'(res) + (SW'(res) << 1);
  end

  // Bisection compare
  logic signed [SW-1:0] diff;
  logic                 at_lt;
  logic [SW-1:0]        errm;
  logic [TW-1:0]        lo_n, hi_n;
  logic [TW:0]          mid;

  always_comb begin
    diff  = sum_q - $signed(SW'(x_q));
    at_lt = diff[SW-1];
    errm  = at_lt ? (~diff + 1'b1) : diff;
    lo_n  = at_lt ? t_q : lo_q;
    hi_n  = at_lt ? hi_q : t_q;
    mid   = {1'b0, lo_n} + {1'b0, hi_n};
  end

  // Final rounding to Q16
  logic [SW-1:0] ymag, yrnd;
  logic [RW-1:0] sat;

  always_comb begin
    ymag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
    yrnd = ymag + RHALF;
    if (rneg_q) begin
      sat = (rnd_q > cbe_pkg::SAT_NEG) ? cbe_pkg::SAT_NEG : rnd_q;
    end else begin
      sat = (rnd_q > cbe_pkg::SAT_POS) ? cbe_pkg::SAT_POS : rnd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    mode_d  = mode_q;
    k_d     = k_q;
    it_d    = it_q;
    valid_d = 1'b0;
    x_d     = x_q;
    t_d     = t_q;
    u_d     = u_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    uu_d    = uu_q;
    tt_d    = tt_q;
    w1_d    = w1_q;
    w2_d    = w2_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    rnd_d   = rnd_q;
    rneg_d  = rneg_q;
    eased_d = eased_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (progress_i <= 0) begin
            eased_d = '0;
            valid_d = 1'b1;
          end else if (progress_i >= $signed({1'b0, cbe_pkg::Q16_ONE})) begin
            eased_d = cbe_pkg::EASE_W'(cbe_pkg::Q16_ONE);
            valid_d = 1'b1;
          end else begin
            // 0 < progress < 1: search starts at t = progress
            x_d     = TW'({progress_i[15:0], {(F-16){1'b0}}});
            t_d     = x_d;
            u_d     = ONE - x_d;
            lo_d    = '0;
            hi_d    = ONE;
            it_d    = '0;
            mode_d  = 1'b0;
            op_d    = OP_UU;
            state_d = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        a_d     = op_a;
        b_d     = BW'(op_b);
        acc_d   = HALF;                       // round to nearest on the way in
        k_d     = '0;
        if (op_q == OP_UU) begin
          sum_d = '0;
        end
        state_d = ST_MUL;
      end

      ST_MUL: begin
        acc_d = acc_q + pp_sh;
        b_d   = b_q >> DIG;
        k_d   = k_q + 1'b1;
        if (k_q == K_LAST) begin
          state_d = ST_STORE;
        end
      end

      ST_STORE: begin
        unique case (op_q)
          OP_UU:   uu_d = res[TW-1:0];
          OP_TT:   tt_d = res[TW-1:0];
          OP_W1:   w1_d = res[TW-1:0];
          OP_W2:   w2_d = res[TW-1:0];
          OP_W3:   sum_d = sum_q + $signed(SW'(res));
          OP_S1,
          OP_S2:   sum_d = op_neg ? (sum_q - $signed(res3)) : (sum_q + $signed(res3));
          default: ;
        endcase
        if (op_q == OP_S2) begin
          state_d = mode_q ? ST_ROUND : ST_CHECK;
        end else begin
          op_d    = op_q + 1'b1;
          state_d = ST_LOAD;
        end
      end

      ST_CHECK: begin
        op_d    = OP_UU;
        state_d = ST_LOAD;
        if (errm < TOL) begin
          mode_d = 1'b1;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          t_d  = mid[TW:1];
          u_d  = ONE - mid[TW:1];
          it_d = it_q + 1'b1;
          if (it_q == IT_LAST) begin
            mode_d = 1'b1;                    // out of steps, last t stands
          end
        end
      end

      ST_ROUND: begin
        rneg_d  = sum_q[SW-1];
        rnd_d   = yrnd[SW-1:F-16];
        state_d = ST_OUT;
      end

      ST_OUT: begin
        eased_d = rneg_q ? (~sat[cbe_pkg::EASE_W-1:0] + 1'b1) : sat[cbe_pkg::EASE_W-1:0];
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_UU;
      mode_q  <= 1'b0;
      k_q     <= '0;
      it_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      mode_q  <= mode_d;
      k_q     <= k_d;
      it_q    <= it_d;
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    t_q     <= t_d;
    u_q     <= u_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    uu_q    <= uu_d;
    tt_q    <= tt_d;
    w1_q    <= w1_d;
    w2_q    <= w2_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
    rnd_q   <= rnd_d;
    rneg_q  <= rneg_d;
    eased_q <= eased_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign eased_o = eased_q;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && progress_i > 0 && progress_i < $signed({1'b0, cbe_pkg::Q16_ONE}))
      |=> busy)
    else $error("in-range progress did not start a search");

  a_clamp_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && progress_i <= 0) |=> (valid_o && eased_o == 0))
    else $error("non-positive progress did not give zero");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && !mode_q) |-> (lo_q <= t_q && t_q <= hi_q))
    else $error("t left its bisection bracket");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result word while still busy");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (k_q <= K_LAST))
    else $error("multiplier digit count overran");
`endif

endmodule : cubic_bezier_easing

`default_nettype wire

FILE: tb/cubic_bezier_easing_tb.sv
// Self-checking testbench for the cubic-bezier easing block, with its own bisection predictor.
`timescale 1ns / 100ps

module cubic_bezier_easing_tb;

  // Same build as the block's defaults; the predictor follows these
  localparam int MAX_STEPS = cbe_pkg::DEF_MAX_ITERATIONS;
  localparam int FRAC      = cbe_pkg::DEF_FRAC_BITS;

  localparam bit [63:0] FONE    = 64'd1 << FRAC;
  localparam bit [63:0] TOL     = (FONE + 64'd500000) / 64'd1000000;
  localparam int        N_PHASE = 10;
  localparam int        N_RAND  = 150;   // progress words per random phase
  localparam int        TAIL    = 1200;  // longer than the block's worst-case search
  localparam int        LIMIT   = 60_000_000;

  // Unknown register indexes run from just above the last one to the top
  localparam logic [cbe_pkg::IDX_W-1:0] REG_TOP = {cbe_pkg::IDX_W{1'b1}};

  typedef logic signed [cbe_pkg::PROG_W-1:0] progress_t;
  typedef logic signed [cbe_pkg::EASE_W-1:0] eased_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the control points, predicts y(t) for each
  // accepted progress word, checks result words in order.
  // --------------------------------------------------------------------------
  class bezier_checker;
    logic [cbe_pkg::CX_W-1:0] cx1, cx2;
    logic [cbe_pkg::CY_W-1:0] cy1, cy2;
    eased_t                   eased_due[$];
    int                       n_bad;
    int                       n_checked;
    int                       n_ends;

    function new();
      cx1       = '0;
      cy1       = '0;
      cx2       = cbe_pkg::Q16_ONE;
      cy2       = cbe_pkg::CY_W'(cbe_pkg::Q16_ONE);
      n_bad     = 0;
      n_checked = 0;
      n_ends    = 0;
    endfunction

    function void set_reg(logic [cbe_pkg::IDX_W-1:0] idx, logic [cbe_pkg::CFG_W-1:0] data);
      case (idx)
        cbe_pkg::REG_X1: cx1 = data[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_Y1: cy1 = data[cbe_pkg::CY_W-1:0];
        cbe_pkg::REG_X2: cx2 = data[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_Y2: cy2 = data[cbe_pkg::CY_W-1:0];
        default: ;  // unknown index, nothing changes
      endcase
    endfunction

    // Unsigned fixed-point product, rounded half up
    function bit [63:0] qmul(bit [63:0] a, bit [63:0] b);
      bit [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod + (128'd1 << (FRAC - 1));
      return prod[FRAC +: 64];
    endfunction

    // Weight times signed coordinate, rounding on the magnitude
    function longint smul(bit [63:0] w, longint c);
      if (c < 0) return -longint'(qmul(w, -c));
      return longint'(qmul(w, c));
    endfunction

    function longint bezier_axis(longint c1, longint c2, bit [63:0] t);
      bit [63:0] u, uu, tt, w1, w2, w3;
      u  = FONE - t;
      uu = qmul(u, u);
      tt = qmul(t, t);
      w1 = qmul(uu, t);
      w2 = qmul(u, tt);
      w3 = qmul(tt, t);
      return 3 * smul(w1, c1) + 3 * smul(w2, c2) + longint'(w3);
    endfunction

    // Control x above one is taken as one
    function longint x_internal(logic [cbe_pkg::CX_W-1:0] cx);
      bit [63:0] v;
      v = (cx > cbe_pkg::Q16_ONE) ? 64'(cbe_pkg::Q16_ONE) : 64'(cx);
      return longint'(v << (FRAC - 16));
    endfunction

    function eased_t ease_of(progress_t prog);
      longint    p, x, x1, x2, y1, y2, at, err, y;
      bit [63:0] lo, hi, t, mag, neg;
      bit        done;
      p = prog;
      if (p <= 0) return '0;
      if (p >= 65536) return eased_t'(65536);
      x  = p <<< (FRAC - 16);
      x1 = x_internal(cx1);
      x2 = x_internal(cx2);
      y1 = longint'($signed(cy1)) <<< (FRAC - 16);
      y2 = longint'($signed(cy2)) <<< (FRAC - 16);
      lo   = 64'd0;
      hi   = FONE;
      t    = x;
      done = 1'b0;
      // bisection from t = progress; last t stands if it never settles
      for (int i = 0; i < MAX_STEPS && !done; i++) begin
        at  = bezier_axis(x1, x2, t);
        err = at - x;
        if (err < 0) err = -err;
        if ($unsigned(err) < TOL) begin
          done = 1'b1;
        end else begin
          if (at < x) lo = t;
          else hi = t;
          t = (lo + hi) >> 1;
        end
      end
      y   = bezier_axis(y1, y2, t);
      mag = (y < 0) ? -y : y;
      mag = (mag + (64'd1 << (FRAC - 17))) >> (FRAC - 16);
      if (y < 0) begin
        if (mag > cbe_pkg::SAT_NEG) mag = cbe_pkg::SAT_NEG;
        neg = 64'd0 - mag;
        return neg[cbe_pkg::EASE_W-1:0];
      end
      if (mag > cbe_pkg::SAT_POS) mag = cbe_pkg::SAT_POS;
      return mag[cbe_pkg::EASE_W-1:0];
    endfunction

    function void note_progress(progress_t prog);
      if (prog <= 0 || prog >= 65536) n_ends++;
      eased_due.push_back(ease_of(prog));
    endfunction

    function void check_eased(eased_t got);
      eased_t want;
      if (eased_due.size() == 0) begin
        $error("eased: result word with nothing due, got %0d", got);
        n_bad++;
        return;
      end
      want = eased_due.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("eased: expected %0d, got %0d", want, got);
        n_bad++;
      end
    endfunction

    function int pending();
      return eased_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block
  // --------------------------------------------------------------------------
  logic                        clk_i    = 1'b0;
  logic                        rst_ni   = 1'b0;
  logic                        start    = 1'b0;
  progress_t                   progress = '0;
  logic                        cfg_we   = 1'b0;
  logic [cbe_pkg::IDX_W-1:0]   cfg_idx  = '0;
  logic [cbe_pkg::CFG_W-1:0]   cfg_data = '0;
  logic                        busy;
  logic                        valid_o;
  eased_t                      eased_o;

  bezier_checker               sb;
  int                          n_curves = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cubic_bezier_easing #(
    .MAX_ITERATIONS     (MAX_STEPS),
    .INTERNAL_FRAC_BITS (FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .progress_i (progress),
    .valid_o    (valid_o),
    .eased_o    (eased_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Result words are one-cycle strobes; sample at the edge that ends them
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_eased(eased_o);
  end

  // --------------------------------------------------------------------------
  // Driving tasks; every call starts and ends on a rising edge
  // --------------------------------------------------------------------------

  // Offer one progress word after a gap; hold start until busy is low
  task automatic send(input progress_t v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    progress <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_progress(v);  // taken at this edge
  endtask

  // Hold off until every due word is back, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [cbe_pkg::IDX_W-1:0] idx,
                           input logic [cbe_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Only called with the block idle
  task automatic load_curve(input logic [cbe_pkg::CFG_W-1:0] x1, y1, x2, y2,
                            input bit stray);
    if (stray) begin
      write_reg(cbe_pkg::IDX_W'($urandom_range(cbe_pkg::REG_Y2 + 1, REG_TOP)),
                cbe_pkg::CFG_W'($urandom));
    end
    write_reg(cbe_pkg::REG_X1, x1);
    write_reg(cbe_pkg::REG_Y1, y1);
    write_reg(cbe_pkg::REG_X2, x2);
    write_reg(cbe_pkg::REG_Y2, y2);
    cfg_we <= 1'b0;
    n_curves++;
  endtask

  function automatic logic [cbe_pkg::CFG_W-1:0] pick_x();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return cbe_pkg::CFG_W'(cbe_pkg::Q16_ONE);
      2:       return {cbe_pkg::CFG_W{1'b1}};                  // clamped to one
      3, 4:    return cbe_pkg::CFG_W'($urandom);               // upper bits too
      default: return cbe_pkg::CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [cbe_pkg::CFG_W-1:0] pick_y();
    case ($urandom_range(0, 11))
      0:       return 20'sh80000;                              // most negative
      1:       return 20'sh7FFFF;                              // most positive
      2:       return cbe_pkg::CFG_W'(-262144);
      3:       return cbe_pkg::CFG_W'(262144);
      4:       return '0;
      5:       return cbe_pkg::CFG_W'(cbe_pkg::Q16_ONE);
      6, 7:    return cbe_pkg::CFG_W'($urandom);
      default: return cbe_pkg::CFG_W'($urandom_range(0, 524288) - 262144);
    endcase
  endfunction

  // Mostly the bisection range, with ends, clamping and the full field
  function automatic progress_t pick_progress();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return progress_t'($urandom_range(1, 65535));
    if (r < 85) return progress_t'($urandom);
    if (r < 90) return ($urandom_range(0, 1) != 0) ? progress_t'(0) : progress_t'(65536);
    if (r < 95) return progress_t'($urandom_range(1, 64));
    return progress_t'($urandom_range(65472, 65535));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    bit burst;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Linear curve from reset: both clamps, both ends, their neighbours
    send(-131072, 0);
    send(-1, $urandom_range(0, 11));
    send(0, 0);
    send(1, $urandom_range(0, 11));
    send(32768, 0);
    send(65535, $urandom_range(0, 11));
    send(65536, 0);
    send(65537, $urandom_range(0, 11));
    send(131071, 0);
    drain();

    // Typical ease curve, with a write to an unknown index
    load_curve(cbe_pkg::CFG_W'(27525), '0, cbe_pkg::CFG_W'(38011),
               cbe_pkg::CFG_W'(cbe_pkg::Q16_ONE), 1'b1);
    send(1, 0);
    send(21845, 3);
    send(49152, 0);
    drain();

    // Control x above one, control y at the field extremes
    load_curve({cbe_pkg::CFG_W{1'b1}}, 20'sh80000, '0, 20'sh7FFFF, 1'b0);
    send(1, 0);
    send(30000, 0);
    send(65535, 7);
    drain();

    // Swapped x, overshooting y in both directions
    load_curve(cbe_pkg::CFG_W'(cbe_pkg::Q16_ONE), cbe_pkg::CFG_W'(262144), '0,
               cbe_pkg::CFG_W'(-262144), 1'b0);
    send(16384, 0);
    send(45000, 11);
    drain();

    // Random phases, each on a fresh curve; some run back to back
    for (int ph = 0; ph < N_PHASE; ph++) begin
      load_curve(pick_x(), pick_y(), pick_x(), pick_y(), $urandom_range(0, 2) == 0);
      burst = (ph % 3 == 1);
      for (int k = 0; k < N_RAND; k++) begin
        send(pick_progress(), burst ? 0 : $urandom_range(0, 11));
        if ($urandom_range(0, 63) == 0) drain();  // sender waits for every word
      end
      drain();
    end

    // Anything arriving late counts as an unexpected word
    repeat (TAIL) @(posedge clk_i);

    $display("checked %0d result words on %0d curve settings", sb.n_checked, n_curves + 1);
    $display("%0d progress words were at or beyond the ends", sb.n_ends);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, well above the slowest correct run
  initial begin
    #LIMIT;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/cbe_pkg.sv
hdl/cubic_bezier_easing.sv
tb/cubic_bezier_easing_tb.sv
